### design/ramp_biased_kinetic_tensor_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ramp-biased kinetic tensor unit.
// Both macros expect signals named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef RAMP_BIASED_KINETIC_TENSOR_UNIT_DEFINES_SVH
`define RAMP_BIASED_KINETIC_TENSOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBKT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbkt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RBKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbkt: next-cycle check failed");

`endif

### design/rbkt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbkt_pkg
// Shared types, constants and helper functions for the kinetic tensor unit.
// ----------------------------------------------------------------------------
package rbkt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ACC_W     = 64;
    localparam int STEP_W    = 6;

    localparam logic [16:0] ONE_Q = 17'(1) << FRAC_BITS;

    localparam logic [STEP_W-1:0] STEP_ACC_END = 6'd22;
    localparam logic [STEP_W-1:0] STEP_EMIT    = 6'd23;
    localparam logic [STEP_W-1:0] STEP_END     = 6'd38;

    typedef enum logic [2:0] {
        REG_COORD_AXIS   = 3'd0,
        REG_VEL_AXIS     = 3'd1,
        REG_COORD_LOW    = 3'd2,
        REG_INV_SPAN     = 3'd3,
        REG_VEL_LOW      = 3'd4,
        REG_VEL_HIGH     = 3'd5,
        REG_ENERGY_SCALE = 3'd6,
        REG_TEMP_SCALE   = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FRAC,
        OP_RAMP,
        OP_VV,
        OP_PL,
        OP_PH,
        OP_TRACE,
        OP_SL,
        OP_SH
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [2:0] idx;
    } op_t;

    typedef struct packed {
        logic load;
        logic publish;
        op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } ctrl_status_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [31:0]        particle_mass;
        logic               in_group;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] temperature;
        logic signed [63:0] ke_xx;
        logic signed [63:0] ke_yy;
        logic signed [63:0] ke_zz;
        logic signed [63:0] ke_xy;
        logic signed [63:0] ke_xz;
        logic signed [63:0] ke_yz;
    } out_item_t;

    function automatic op_t op_at(input logic [STEP_W-1:0] step);
        op_t               o;
        logic [STEP_W-1:0] rel;
        begin
            o.kind = OP_NOP;
            o.idx  = 3'd0;
            rel    = '0;
            if (step == 6'd0) begin
                o.kind = OP_FRAC;
            end else if (step == 6'd2) begin
                o.kind = OP_RAMP;
            end else if (step >= 6'd4 && step <= 6'd9) begin
                rel    = step - 6'd4;
                o.kind = OP_VV;
                o.idx  = rel[2:0];
            end else if (step >= 6'd10 && step <= 6'd21) begin
                rel    = step - 6'd10;
                o.kind = rel[0] ? OP_PH : OP_PL;
                o.idx  = rel[3:1];
            end else if (step == STEP_EMIT) begin
                o.kind = OP_TRACE;
            end else if (step >= 6'd24 && step <= 6'd37) begin
                rel    = step - 6'd24;
                o.kind = rel[0] ? OP_SH : OP_SL;
                o.idx  = rel[3:1];
            end
            return o;
        end
    endfunction

    function automatic logic [1:0] axis_clamp(input logic [1:0] a);
        return (a == 2'd3) ? 2'd2 : a;
    endfunction

    // Tensor order is xx yy zz xy xz yz.
    function automatic logic [1:0] tensor_ia(input logic [2:0] k);
        logic [1:0] r;
        begin
            case (k)
                3'd1:    r = 2'd1;
                3'd2:    r = 2'd2;
                3'd5:    r = 2'd1;
                default: r = 2'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [1:0] tensor_ib(input logic [2:0] k);
        logic [1:0] r;
        begin
            case (k)
                3'd1:    r = 2'd1;
                3'd2:    r = 2'd2;
                3'd3:    r = 2'd1;
                3'd4:    r = 2'd2;
                3'd5:    r = 2'd2;
                default: r = 2'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        begin
            s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
            if (s[ACC_W] != s[ACC_W-1]) begin
                return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            end
            return s[ACC_W-1:0];
        end
    endfunction

endpackage

### design/rbkt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbkt_in_if
// Valid/ready channel carrying one particle per transfer.
// ----------------------------------------------------------------------------
interface rbkt_in_if
    import rbkt_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### design/rbkt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbkt_out_if
// Valid/ready channel carrying one tensor result per transfer.
// ----------------------------------------------------------------------------
interface rbkt_out_if
    import rbkt_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### design/rbkt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbkt_ctrl
// Sequencer that steps the shared multiplier through one particle's work.
// ----------------------------------------------------------------------------
`include "ramp_biased_kinetic_tensor_unit_defines.svh"

module rbkt_ctrl
    import rbkt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_group,
    input  logic         in_last,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              last_reg;

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        cmd.load       = in_valid && in_ready;
        cmd.op         = (state_reg == ST_RUN) ? op_at(step_reg) : op_t'{kind: OP_NOP, idx: 3'd0};
        cmd.publish    = (state_reg == ST_RUN) && (step_reg == STEP_END);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg <= in_last;
                        if (in_group)
                        begin
                            state_reg <= ST_RUN;
                            step_reg  <= '0;
                        end
                        else if (in_last)
                        begin
                            state_reg <= ST_WAIT;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (step_reg == STEP_ACC_END)
                    begin
                        state_reg <= last_reg ? ST_WAIT : ST_IDLE;
                    end
                    else if (step_reg == STEP_END)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_WAIT:
                begin
                    if (!status.out_busy)
                    begin
                        state_reg <= ST_RUN;
                        step_reg  <= STEP_EMIT;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `RBKT_ASSERT_NOW(a_publish_free, cmd.publish, !status.out_busy)
    `RBKT_ASSERT_NEXT(a_publish_idle, cmd.publish, state_reg == ST_IDLE)
    `RBKT_ASSERT_NOW(a_load_on_transfer, cmd.load, in_valid && in_ready)
    `RBKT_ASSERT_NOW(a_step_range, state_reg == ST_RUN, step_reg <= STEP_END)

endmodule

### design/rbkt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbkt_datapath
// Configuration registers, particle registers, shared multiplier, tensor sums.
// ----------------------------------------------------------------------------
module rbkt_datapath
    import rbkt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  in_item_t      in_item,
    input  ctrl_cmd_t     cmd,
    output ctrl_status_t  status,
    rbkt_out_if.source    result
);

    logic [1:0]         coord_axis_reg;
    logic [1:0]         vel_axis_reg;
    logic signed [31:0] coord_low_reg;
    logic signed [31:0] inv_span_reg;
    logic signed [31:0] vel_low_reg;
    logic signed [31:0] vel_high_reg;
    logic [31:0]        energy_scale_reg;
    logic [31:0]        temp_scale_reg;

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic [31:0]        mass_reg;
    logic [16:0]        frac_reg;
    logic [46:0]        pmag_reg [6];
    logic               psign_reg [6];
    logic [63:0]        part_reg;
    logic signed [63:0] trace_reg;
    logic signed [63:0] sums_reg [6];
    logic [64:0]        prod_reg;
    logic               sign_reg;
    op_t                wb_op_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic [1:0]         ca;
    logic [1:0]         va;
    logic signed [32:0] pos_diff;
    logic signed [32:0] vel_diff;
    logic [31:0]        inv_mag;
    logic [1:0]         sel_a;
    logic [1:0]         sel_b;
    logic [2:0]         sum_sel;
    logic signed [63:0] scale_src;
    logic [63:0]        scale_mag;
    logic [31:0]        scale_b;
    logic [32:0]        mul_a;
    logic [31:0]        mul_b;
    logic               mul_sign;
    logic [64:0]        mul_p;
    logic [48:0]        frac_q;
    logic [16:0]        frac_val;
    logic [33:0]        ramp_q;
    logic signed [34:0] ramp_term;
    logic signed [35:0] ramp_val;
    logic signed [36:0] vel_adj;
    logic signed [31:0] vel_sat;
    logic [79:0]        term_full;
    logic [63:0]        term_mag;
    logic signed [63:0] term_val;
    logic [95:0]        scl_full;
    logic [79:0]        scl_q;
    logic signed [63:0] scl_val;
    logic signed [63:0] trace_val;

    assign status.out_busy = out_valid_reg;
    assign result.valid    = out_valid_reg;
    assign result.payload  = out_reg;

    assign ca = axis_clamp(coord_axis_reg);
    assign va = axis_clamp(vel_axis_reg);

    always_comb
    begin
        pos_diff  = {pos_reg[ca][31], pos_reg[ca]} - {coord_low_reg[31], coord_low_reg};
        vel_diff  = {vel_high_reg[31], vel_high_reg} - {vel_low_reg[31], vel_low_reg};
        inv_mag   = inv_span_reg[31] ? 32'(-inv_span_reg) : 32'(inv_span_reg);
        sel_a     = tensor_ia(cmd.op.idx);
        sel_b     = tensor_ib(cmd.op.idx);
        sum_sel   = (cmd.op.idx == 3'd0) ? 3'd0 : cmd.op.idx - 3'd1;
        scale_src = (cmd.op.idx == 3'd0) ? trace_reg : sums_reg[sum_sel];
        scale_mag = scale_src[63] ? 64'(-scale_src) : 64'(scale_src);
        scale_b   = (cmd.op.idx == 3'd0) ? temp_scale_reg : energy_scale_reg;
        trace_val = sat_add(sat_add(sums_reg[0], sums_reg[1]), sums_reg[2]);
        mul_a     = '0;
        mul_b     = '0;
        mul_sign  = 1'b0;
        case (cmd.op.kind)
            OP_FRAC:
            begin
                mul_a    = pos_diff[32] ? 33'(-pos_diff) : 33'(pos_diff);
                mul_b    = inv_mag;
                mul_sign = pos_diff[32] ^ inv_span_reg[31];
            end
            OP_RAMP:
            begin
                mul_a    = vel_diff[32] ? 33'(-vel_diff) : 33'(vel_diff);
                mul_b    = {15'd0, frac_reg};
                mul_sign = vel_diff[32];
            end
            OP_VV:
            begin
                mul_a    = {1'b0, vel_reg[sel_a][31] ? 32'(-vel_reg[sel_a]) : 32'(vel_reg[sel_a])};
                mul_b    = vel_reg[sel_b][31] ? 32'(-vel_reg[sel_b]) : 32'(vel_reg[sel_b]);
                mul_sign = vel_reg[sel_a][31] ^ vel_reg[sel_b][31];
            end
            OP_PL:
            begin
                mul_a    = {1'b0, pmag_reg[cmd.op.idx][31:0]};
                mul_b    = mass_reg;
                mul_sign = psign_reg[cmd.op.idx];
            end
            OP_PH:
            begin
                mul_a    = {18'd0, pmag_reg[cmd.op.idx][46:32]};
                mul_b    = mass_reg;
                mul_sign = psign_reg[cmd.op.idx];
            end
            OP_SL:
            begin
                mul_a    = {1'b0, scale_mag[31:0]};
                mul_b    = scale_b;
                mul_sign = scale_src[63];
            end
            OP_SH:
            begin
                mul_a    = {1'b0, scale_mag[63:32]};
                mul_b    = scale_b;
                mul_sign = scale_src[63];
            end
            default:
            begin
                mul_a    = '0;
            end
        endcase
        mul_p = 65'(mul_a) * 65'(mul_b);
    end

    always_comb
    begin
        frac_q    = prod_reg[64:16];
        if (sign_reg)
            frac_val = 17'd0;
        else if (frac_q > 49'(ONE_Q))
            frac_val = ONE_Q;
        else
            frac_val = frac_q[16:0];

        ramp_q    = prod_reg[49:16];
        ramp_term = sign_reg ? -$signed({1'b0, ramp_q}) : $signed({1'b0, ramp_q});
        ramp_val  = 36'(vel_low_reg) + 36'(ramp_term);
        vel_adj   = 37'(vel_reg[va]) - 37'(ramp_val);
        if (vel_adj > 37'sh0_7FFF_FFFF)
            vel_sat = 32'sh7FFF_FFFF;
        else if (vel_adj < -37'sh0_8000_0000)
            vel_sat = 32'sh8000_0000;
        else
            vel_sat = vel_adj[31:0];

        term_full = {prod_reg[47:0], 32'd0} + {16'd0, part_reg};
        term_mag  = term_full[79:16];
        term_val  = sign_reg ? $signed(-term_mag) : $signed(term_mag);

        scl_full  = {prod_reg[63:0], 32'd0} + {32'd0, part_reg};
        scl_q     = scl_full[95:16];
        if (sign_reg)
        begin
            if (scl_q > 80'h0000_8000_0000_0000_0000)
                scl_val = 64'sh8000_0000_0000_0000;
            else
                scl_val = $signed(-scl_q[63:0]);
        end
        else
        begin
            if (scl_q > 80'h0000_7FFF_FFFF_FFFF_FFFF)
                scl_val = 64'sh7FFF_FFFF_FFFF_FFFF;
            else
                scl_val = $signed(scl_q[63:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_axis_reg   <= 2'd0;
            vel_axis_reg     <= 2'd0;
            coord_low_reg    <= '0;
            inv_span_reg     <= 32'(ONE_Q);
            vel_low_reg      <= '0;
            vel_high_reg     <= '0;
            energy_scale_reg <= 32'(ONE_Q);
            temp_scale_reg   <= 32'(ONE_Q);
            out_valid_reg    <= 1'b0;
            wb_op_reg        <= '{kind: OP_NOP, idx: 3'd0};
            for (int i = 0; i < 6; i++)
                sums_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_COORD_AXIS:   coord_axis_reg   <= cfg_data[1:0];
                    REG_VEL_AXIS:     vel_axis_reg     <= cfg_data[1:0];
                    REG_COORD_LOW:    coord_low_reg    <= cfg_data;
                    REG_INV_SPAN:     inv_span_reg     <= cfg_data;
                    REG_VEL_LOW:      vel_low_reg      <= cfg_data;
                    REG_VEL_HIGH:     vel_high_reg     <= cfg_data;
                    REG_ENERGY_SCALE: energy_scale_reg <= cfg_data;
                    REG_TEMP_SCALE:   temp_scale_reg   <= cfg_data;
                    default:          coord_axis_reg   <= coord_axis_reg;
                endcase
            end
            wb_op_reg <= cmd.op;
            if (wb_op_reg.kind == OP_PH)
                sums_reg[wb_op_reg.idx] <= sat_add(sums_reg[wb_op_reg.idx], term_val);
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < 6; i++)
                    sums_reg[i] <= '0;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        sign_reg <= mul_sign;
        if (cmd.load)
        begin
            pos_reg[0] <= in_item.pos_x;
            pos_reg[1] <= in_item.pos_y;
            pos_reg[2] <= in_item.pos_z;
            vel_reg[0] <= in_item.vel_x;
            vel_reg[1] <= in_item.vel_y;
            vel_reg[2] <= in_item.vel_z;
            mass_reg   <= in_item.particle_mass;
        end
        if (cmd.op.kind == OP_TRACE)
            trace_reg <= trace_val;
        case (wb_op_reg.kind)
            OP_FRAC:
            begin
                frac_reg <= frac_val;
            end
            OP_RAMP:
            begin
                vel_reg[va] <= vel_sat;
            end
            OP_VV:
            begin
                pmag_reg[wb_op_reg.idx]  <= prod_reg[62:16];
                psign_reg[wb_op_reg.idx] <= sign_reg;
            end
            OP_PL, OP_SL:
            begin
                part_reg <= prod_reg[63:0];
            end
            OP_SH:
            begin
                case (wb_op_reg.idx)
                    3'd0:    out_reg.temperature <= scl_val;
                    3'd1:    out_reg.ke_xx       <= scl_val;
                    3'd2:    out_reg.ke_yy       <= scl_val;
                    3'd3:    out_reg.ke_zz       <= scl_val;
                    3'd4:    out_reg.ke_xy       <= scl_val;
                    3'd5:    out_reg.ke_xz       <= scl_val;
                    default: out_reg.ke_yz       <= scl_val;
                endcase
            end
            default:
            begin
                part_reg <= part_reg;
            end
        endcase
    end

endmodule

### design/ramp_biased_kinetic_tensor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramp_biased_kinetic_tensor_unit
// Kinetic energy tensor of a particle group with a linear velocity ramp removed.
// ----------------------------------------------------------------------------
// One particle is taken at a time through a single shared 33 by 32 bit
// multiplier stepped by a sequencer. A group particle holds the block through
// its accumulation steps, while a particle outside the group is only taken in.
// A particle marked last then also has the scaled tensor and temperature
// emitted, after any wait for the previous result to be taken. Results
// sit in an output register, and the next particle is accepted while they wait.

module ramp_biased_kinetic_tensor_unit
    import rbkt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    rbkt_in_if.sink     particle,
    rbkt_out_if.source  result
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    rbkt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (particle.valid),
        .in_group (particle.payload.in_group),
        .in_last  (particle.payload.last),
        .in_ready (particle.ready),
        .status   (status),
        .cmd      (cmd)
    );

    rbkt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (particle.payload),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule
